// ===== rtl/free_list_allocator_macros.svh =====
//------------------------------------------------------------------------------
// Free list allocator assertion macros
// Shared property wrappers, clocked on clk_i and disabled while rst_ni is low.
//------------------------------------------------------------------------------
`ifndef FREE_LIST_ALLOCATOR_MACROS_SVH
`define FREE_LIST_ALLOCATOR_MACROS_SVH

// Check the consequent in the same cycle as the antecedent
`define FLA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("free_list_allocator: property violated");

// Check the consequent in the cycle after the antecedent
`define FLA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("free_list_allocator: property violated");

`endif

// ===== rtl/fla_pkg.sv =====
//------------------------------------------------------------------------------
// Free list allocator package
// Sizes, codes, request and result types, and controller/datapath links.
//------------------------------------------------------------------------------
package fla_pkg;

  // Table sizes and allocation granularity
  localparam int unsigned MAX_FREE     = 16;
  localparam int unsigned MAX_ALLOCS   = 16;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned NODE_BYTES   = 16;
  // Must be a power of two
  localparam int unsigned MIN_ALIGN    = 8;

  // Field widths
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ALIGN_W   = 17;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned STAT_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Derived widths
  localparam int unsigned IDX_W    = $clog2(MAX_FREE);
  localparam int unsigned CNT_W    = $clog2(MAX_FREE + 1);
  localparam int unsigned HIDX_W   = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;
  localparam int unsigned HCNT_W   = $clog2(MAX_ALLOCS + 1);
  localparam int unsigned PAD_W    = ALIGN_W + 1;
  localparam int unsigned REQ_W    = DATA_W + 1;
  localparam int unsigned DCNT_W   = $clog2(DATA_W);
  localparam int unsigned MINPAD_W = $clog2(HEADER_BYTES + 2 * MIN_ALIGN + 1);

  // Register reset values
  localparam logic [DATA_W-1:0] ARENA_BASE_RST = 32'd0;
  localparam logic [DATA_W-1:0] ARENA_SIZE_RST = 32'd65536;
  localparam logic              FIT_FIRST      = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REBUILD = 2'd2,
    OP_NONE    = 2'd3
  } fla_op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_ZERO    = 3'd1,
    STAT_NOFIT   = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_UNKNOWN = 3'd4
  } fla_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ARENA_BASE = 2'd0,
    CFG_ARENA_SIZE = 2'd1,
    CFG_FIT_POLICY = 2'd2
  } fla_cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_DIV,
    S_PAD,
    S_RAISE,
    S_CHECK,
    S_ALLOC_END,
    S_LOOKUP,
    S_FSCAN,
    S_DECIDE,
    S_FUPDATE,
    S_FINISH
  } fla_state_e;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [DATA_W-1:0]  req_size;
    logic [ALIGN_W-1:0] align;
    logic [DATA_W-1:0]  free_addr;
  } fla_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_addr;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] used_bytes;
    logic [DATA_W-1:0] peak_bytes;
  } fla_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic        load;
    logic        rebuild;
    logic        status_we;
    fla_status_e status;
    logic        scan_init;
    logic        div_start;
    logic        div_step;
    logic        pad_init;
    logic        pad_raise;
    logic        check;
    logic        commit;
    logic        lk_init;
    logic        lk_step;
    logic        lk_capture;
    logic        fs_step;
    logic        decide;
    logic        free_update;
    logic        out_load;
  } fla_cmd_t;

  // Datapath to controller
  typedef struct packed {
    fla_op_e op;
    logic    size_zero;
    logic    addr_zero;
    logic    scan_done;
    logic    div_last;
    logic    pad_ok;
    logic    fit;
    logic    first_fit;
    logic    found;
    logic    hdr_full;
    logic    lk_end;
    logic    lk_hit;
    logic    fs_stop;
    logic    free_full;
    logic    out_free;
  } fla_stat_t;

  // Header padding at minimum alignment for the address that follows a split
  function automatic logic [MINPAD_W-1:0] pad_min(input logic [REQ_W-1:0] addr);
    logic [MINPAD_W-1:0] p;
    p = MINPAD_W'(MIN_ALIGN) - MINPAD_W'(addr % MIN_ALIGN);
    for (int k = 0; k <= HEADER_BYTES / MIN_ALIGN; k++) begin
      if (p < MINPAD_W'(HEADER_BYTES)) begin
        p = p + MINPAD_W'(MIN_ALIGN);
      end
    end
    return p;
  endfunction

endpackage

// ===== rtl/fla_ctrl.sv =====
//------------------------------------------------------------------------------
// Free list allocator controller
// Sequences search, division, split, lookup and merge steps of one request.
//------------------------------------------------------------------------------
module fla_ctrl import fla_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  fla_stat_t st_i,
  output fla_cmd_t  cmd_o
);

  fla_state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Advance through the request and issue datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.status = STAT_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st_i.op)
          OP_ALLOC: begin
            if (st_i.size_zero) begin
              cmd_o.status_we = 1'b1;
              cmd_o.status = STAT_ZERO;
              state_d = S_FINISH;
            end else begin
              cmd_o.scan_init = 1'b1;
              state_d = S_SCAN;
            end
          end
          OP_FREE: begin
            if (st_i.addr_zero) begin
              state_d = S_FINISH;
            end else begin
              cmd_o.lk_init = 1'b1;
              state_d = S_LOOKUP;
            end
          end
          OP_REBUILD: begin
            cmd_o.rebuild = 1'b1;
            state_d = S_FINISH;
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end
      S_SCAN: begin
        if (st_i.scan_done) begin
          state_d = S_ALLOC_END;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (st_i.div_last) begin
          state_d = S_PAD;
        end
      end
      S_PAD: begin
        cmd_o.pad_init = 1'b1;
        state_d = S_RAISE;
      end
      S_RAISE: begin
        if (st_i.pad_ok) begin
          state_d = S_CHECK;
        end else begin
          cmd_o.pad_raise = 1'b1;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (st_i.fit && st_i.first_fit) begin
          state_d = S_ALLOC_END;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_ALLOC_END: begin
        if (!st_i.found) begin
          cmd_o.status_we = 1'b1;
          cmd_o.status = STAT_NOFIT;
        end else if (st_i.hdr_full) begin
          cmd_o.status_we = 1'b1;
          cmd_o.status = STAT_FULL;
        end else begin
          cmd_o.commit = 1'b1;
        end
        state_d = S_FINISH;
      end
      S_LOOKUP: begin
        if (st_i.lk_end) begin
          cmd_o.status_we = 1'b1;
          cmd_o.status = STAT_UNKNOWN;
          state_d = S_FINISH;
        end else if (st_i.lk_hit) begin
          cmd_o.lk_capture = 1'b1;
          state_d = S_FSCAN;
        end else begin
          cmd_o.lk_step = 1'b1;
        end
      end
      S_FSCAN: begin
        cmd_o.fs_step = 1'b1;
        if (st_i.fs_stop) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = S_FUPDATE;
      end
      S_FUPDATE: begin
        if (st_i.free_full) begin
          cmd_o.status_we = 1'b1;
          cmd_o.status = STAT_FULL;
        end else begin
          cmd_o.free_update = 1'b1;
        end
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/fla_dp.sv =====
//------------------------------------------------------------------------------
// Free list allocator datapath
// Free block table, header records, remainder divider, counters and result.
//------------------------------------------------------------------------------
module fla_dp import fla_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fla_req_t             in_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output fla_rsp_t             out_data_o,
  input  fla_cmd_t             cmd_i,
  output fla_stat_t            st_o
);

  // Configuration
  logic [DATA_W-1:0] base_q, arena_size_q;
  logic              policy_q;

  // Request
  fla_op_e            op_q;
  logic [DATA_W-1:0]  req_size_q, free_addr_q;
  logic [ALIGN_W-1:0] align_q;

  // Free block table
  logic [DATA_W-1:0] fs_q [MAX_FREE];
  logic [DATA_W-1:0] fl_q [MAX_FREE];
  logic [DATA_W-1:0] fs_d [MAX_FREE];
  logic [DATA_W-1:0] fl_d [MAX_FREE];
  logic [DATA_W-1:0] dn_s [MAX_FREE];
  logic [DATA_W-1:0] dn_l [MAX_FREE];
  logic [DATA_W-1:0] up_s [MAX_FREE];
  logic [DATA_W-1:0] up_l [MAX_FREE];
  logic [CNT_W-1:0]  count_q, count_d;

  // Header records
  logic [DATA_W-1:0]     hdr_addr_q [MAX_ALLOCS];
  logic [DATA_W-1:0]     hdr_size_q [MAX_ALLOCS];
  logic [PAD_W-1:0]      hdr_pad_q  [MAX_ALLOCS];
  logic [MAX_ALLOCS-1:0] hdr_valid_q;

  // Search and divider
  logic [CNT_W-1:0]   idx_q;
  logic [DCNT_W-1:0]  div_cnt_q;
  logic [ALIGN_W-1:0] rem_q;
  logic [DATA_W-1:0]  quo_q;
  logic [PAD_W-1:0]   pad_q;
  logic               found_q;
  logic [IDX_W-1:0]   best_idx_q;
  logic [DATA_W-1:0]  best_start_q, best_len_q, best_req_q, best_diff_q;
  logic [PAD_W-1:0]   best_pad_q;

  // Free path
  logic [HCNT_W-1:0] lk_q;
  logic [HIDX_W-1:0] slot_q;
  logic [DATA_W-1:0] bstart_q, blen_q;
  logic [DATA_W-1:0] prev_start_q, prev_len_q, next_start_q, next_len_q;
  logic              next_ok_q, mnext_q, mprev_q;

  // Counters and result
  logic [DATA_W-1:0] used_q, peak_q, res_addr_q;
  fla_status_e       res_status_q;
  logic              out_valid_q;
  fla_rsp_t          out_data_q;

  // Combinational terms
  logic [ALIGN_W-1:0] a_eff;
  logic [DATA_W-1:0]  size_eff, rd_start, rd_len;
  logic [PAD_W-1:0]   rem_sh, a_ext;
  logic [ALIGN_W-1:0] rem_next;
  logic [REQ_W-1:0]   req_w, end_addr, min_req, room, used_add;
  logic [DATA_W-1:0]  diff, rebuild_len, blk, new_addr, used_sat, used_sub, merge_len;
  logic [DATA_W-1:0]  peak_max;
  logic               fit, take, split, fs_stop, mnext, mprev;
  logic [IDX_W-1:0]   rd_i, p_idx, pm1;
  logic [HIDX_W-1:0]  lk_i, slot_free;
  logic [CNT_W-1:0]   pm1_w;

  assign a_eff    = (align_q < ALIGN_W'(MIN_ALIGN)) ? ALIGN_W'(MIN_ALIGN) : align_q;
  assign size_eff = (req_size_q < DATA_W'(NODE_BYTES)) ? DATA_W'(NODE_BYTES) : req_size_q;
  assign rd_i     = idx_q[IDX_W-1:0];
  assign rd_start = fs_q[rd_i];
  assign rd_len   = fl_q[rd_i];
  assign lk_i     = lk_q[HIDX_W-1:0];

  // One quotient bit per step: shift in, compare, subtract
  assign rem_sh   = {rem_q, quo_q[DATA_W-1]};
  assign a_ext    = {1'b0, a_eff};
  assign rem_next = (rem_sh >= a_ext) ? ALIGN_W'(rem_sh - a_ext) : rem_sh[ALIGN_W-1:0];

  // Fit test for the entry under the scan index
  assign req_w = REQ_W'(size_eff) + REQ_W'(pad_q);
  assign fit   = {1'b0, rd_len} >= req_w;
  assign diff  = rd_len - req_w[DATA_W-1:0];
  assign take  = fit && ((policy_q == FIT_FIRST) || !found_q || (diff < best_diff_q));

  // Split decision and new header for the chosen block
  assign end_addr = REQ_W'(best_start_q) + REQ_W'(best_req_q);
  assign min_req  = REQ_W'(NODE_BYTES) + REQ_W'(pad_min(end_addr));
  assign split    = REQ_W'(best_diff_q) >= min_req;
  assign blk      = split ? best_req_q : best_len_q;
  assign new_addr = best_start_q + DATA_W'(best_pad_q);

  // Arena length clipped to the top of the address space
  assign room        = {1'b1, {DATA_W{1'b0}}} - REQ_W'(base_q);
  assign rebuild_len = (REQ_W'(arena_size_q) > room) ? room[DATA_W-1:0] : arena_size_q;

  // Saturating byte counters
  assign used_add = REQ_W'(used_q) + REQ_W'(blk);
  assign used_sat = used_add[DATA_W] ? {DATA_W{1'b1}} : used_add[DATA_W-1:0];
  assign used_sub = (used_q >= blen_q) ? (used_q - blen_q) : '0;
  assign peak_max = (used_q > peak_q) ? used_q : peak_q;

  // Free path: position, neighbor tests, merged length
  assign fs_stop   = (idx_q >= count_q) || (bstart_q < rd_start);
  assign mnext     = next_ok_q && ((REQ_W'(bstart_q) + REQ_W'(blen_q)) == REQ_W'(next_start_q));
  assign mprev     = (idx_q != '0) &&
                     ((REQ_W'(prev_start_q) + REQ_W'(prev_len_q)) == REQ_W'(bstart_q));
  assign merge_len = (mprev_q ? prev_len_q : '0) + blen_q + (mnext_q ? next_len_q : '0);
  assign p_idx     = idx_q[IDX_W-1:0];
  assign pm1_w     = idx_q - CNT_W'(1);
  assign pm1       = pm1_w[IDX_W-1:0];

  // First free header slot
  always_comb begin
    slot_free = '0;
    for (int i = MAX_ALLOCS - 1; i >= 0; i--) begin
      if (!hdr_valid_q[i]) begin
        slot_free = HIDX_W'(i);
      end
    end
  end

  // Neighbor views of the table for shifting
  always_comb begin
    for (int i = 0; i < MAX_FREE - 1; i++) begin
      dn_s[i] = fs_q[i+1];
      dn_l[i] = fl_q[i+1];
    end
    dn_s[MAX_FREE-1] = fs_q[MAX_FREE-1];
    dn_l[MAX_FREE-1] = fl_q[MAX_FREE-1];
    up_s[0] = fs_q[0];
    up_l[0] = fl_q[0];
    for (int i = 1; i < MAX_FREE; i++) begin
      up_s[i] = fs_q[i-1];
      up_l[i] = fl_q[i-1];
    end
  end

  // Next free table: rebuild, split or remove on allocate, merge or insert on free
  always_comb begin
    fs_d = fs_q;
    fl_d = fl_q;
    count_d = count_q;
    if (cmd_i.rebuild) begin
      fs_d[0] = base_q;
      fl_d[0] = rebuild_len;
      count_d = CNT_W'(1);
    end else if (cmd_i.commit) begin
      if (split) begin
        fs_d[best_idx_q] = end_addr[DATA_W-1:0];
        fl_d[best_idx_q] = best_diff_q;
      end else begin
        for (int i = 0; i < MAX_FREE; i++) begin
          if (IDX_W'(i) >= best_idx_q) begin
            fs_d[i] = dn_s[i];
            fl_d[i] = dn_l[i];
          end
        end
        count_d = count_q - CNT_W'(1);
      end
    end else if (cmd_i.free_update) begin
      if (mprev_q) begin
        if (mnext_q) begin
          for (int i = 0; i < MAX_FREE; i++) begin
            if (IDX_W'(i) >= p_idx) begin
              fs_d[i] = dn_s[i];
              fl_d[i] = dn_l[i];
            end
          end
          count_d = count_q - CNT_W'(1);
        end
        fl_d[pm1] = merge_len;
      end else if (mnext_q) begin
        fs_d[p_idx] = bstart_q;
        fl_d[p_idx] = merge_len;
      end else begin
        for (int i = 0; i < MAX_FREE; i++) begin
          if (IDX_W'(i) > p_idx) begin
            fs_d[i] = up_s[i];
            fl_d[i] = up_l[i];
          end
        end
        fs_d[p_idx] = bstart_q;
        fl_d[p_idx] = merge_len;
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  // Hold the free table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i < MAX_FREE; i++) begin
        fs_q[i] <= '0;
        fl_q[i] <= '0;
      end
      fs_q[0] <= ARENA_BASE_RST;
      fl_q[0] <= ARENA_SIZE_RST;
      count_q <= CNT_W'(1);
    end else begin
      fs_q <= fs_d;
      fl_q <= fl_d;
      count_q <= count_d;
    end
  end

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= ARENA_BASE_RST;
      arena_size_q <= ARENA_SIZE_RST;
      policy_q <= FIT_FIRST;
    end else if (cfg_we_i) begin
      case (fla_cfg_e'(cfg_index_i))
        CFG_ARENA_BASE: base_q <= cfg_data_i;
        CFG_ARENA_SIZE: arena_size_q <= cfg_data_i;
        CFG_FIT_POLICY: policy_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Header record contents
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hdr_addr_q[slot_free] <= new_addr;
      hdr_size_q[slot_free] <= blk;
      hdr_pad_q[slot_free] <= best_pad_q - PAD_W'(HEADER_BYTES);
    end
  end

  // Header valid bits, byte counters, output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_valid_q <= '0;
      used_q <= '0;
      peak_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.rebuild) begin
        hdr_valid_q <= '0;
        used_q <= '0;
        peak_q <= '0;
      end else if (cmd_i.commit) begin
        hdr_valid_q[slot_free] <= 1'b1;
        used_q <= used_sat;
      end else if (cmd_i.free_update) begin
        hdr_valid_q[slot_q] <= 1'b0;
        used_q <= used_sub;
      end
      if (cmd_i.out_load) begin
        peak_q <= peak_max;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request, search, divider and free path registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= fla_op_e'(in_data_i.op);
      req_size_q <= in_data_i.req_size;
      align_q <= in_data_i.align;
      free_addr_q <= in_data_i.free_addr;
      res_status_q <= STAT_OK;
      res_addr_q <= '0;
    end
    if (cmd_i.status_we) begin
      res_status_q <= cmd_i.status;
    end
    if (cmd_i.scan_init) begin
      idx_q <= '0;
      found_q <= 1'b0;
    end
    if (cmd_i.div_start) begin
      quo_q <= rd_start;
      rem_q <= '0;
      div_cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      rem_q <= rem_next;
      div_cnt_q <= div_cnt_q + DCNT_W'(1);
    end
    if (cmd_i.pad_init) begin
      pad_q <= a_ext - PAD_W'(rem_q);
    end
    if (cmd_i.pad_raise) begin
      pad_q <= pad_q + a_ext;
    end
    if (cmd_i.check) begin
      idx_q <= idx_q + CNT_W'(1);
      if (take) begin
        found_q <= 1'b1;
        best_idx_q <= rd_i;
        best_start_q <= rd_start;
        best_len_q <= rd_len;
        best_req_q <= req_w[DATA_W-1:0];
        best_diff_q <= diff;
        best_pad_q <= pad_q;
      end
    end
    if (cmd_i.commit) begin
      res_addr_q <= new_addr;
    end
    if (cmd_i.lk_init) begin
      lk_q <= '0;
    end
    if (cmd_i.lk_step) begin
      lk_q <= lk_q + HCNT_W'(1);
    end
    if (cmd_i.lk_capture) begin
      slot_q <= lk_i;
      bstart_q <= free_addr_q - DATA_W'(HEADER_BYTES) - DATA_W'(hdr_pad_q[lk_i]);
      blen_q <= hdr_size_q[lk_i];
      idx_q <= '0;
    end
    if (cmd_i.fs_step) begin
      if (!fs_stop) begin
        prev_start_q <= rd_start;
        prev_len_q <= rd_len;
        idx_q <= idx_q + CNT_W'(1);
      end else begin
        next_start_q <= rd_start;
        next_len_q <= rd_len;
        next_ok_q <= (idx_q < count_q);
      end
    end
    if (cmd_i.decide) begin
      mnext_q <= mnext;
      mprev_q <= mprev;
    end
    if (cmd_i.out_load) begin
      out_data_q.data_addr <= res_addr_q;
      out_data_q.status <= res_status_q;
      out_data_q.used_bytes <= used_q;
      out_data_q.peak_bytes <= peak_max;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Report status to the controller
  always_comb begin
    st_o.op        = op_q;
    st_o.size_zero = (req_size_q == '0);
    st_o.addr_zero = (free_addr_q == '0);
    st_o.scan_done = (idx_q >= count_q);
    st_o.div_last  = (div_cnt_q == DCNT_W'(DATA_W - 1));
    st_o.pad_ok    = (pad_q >= PAD_W'(HEADER_BYTES));
    st_o.fit       = fit;
    st_o.first_fit = (policy_q == FIT_FIRST);
    st_o.found     = found_q;
    st_o.hdr_full  = &hdr_valid_q;
    st_o.lk_end    = (lk_q == HCNT_W'(MAX_ALLOCS));
    st_o.lk_hit    = hdr_valid_q[lk_i] && (hdr_addr_q[lk_i] == free_addr_q);
    st_o.fs_stop   = fs_stop;
    st_o.free_full = !mnext_q && !mprev_q && (count_q >= CNT_W'(MAX_FREE));
    st_o.out_free  = !out_valid_q || !out_stall_i;
  end

endmodule

// ===== rtl/free_list_allocator.sv =====
//------------------------------------------------------------------------------
// Free list allocator
// Address-ordered free block table with first or best fit and coalescing.
//------------------------------------------------------------------------------
//  channel   handshake             payload
//  in        in_valid_i/in_stall_o   fla_req_t  (op, req_size, align, free_addr)
//  out       out_valid_o/out_stall_i fla_rsp_t  (data_addr, status, used, peak)
//  cfg       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  One request at a time. Reset, no-op and free of address zero go straight to the result.
//  Allocate: each free block visited runs the one-bit-per-cycle remainder divider
//  and then the alignment raise steps; first fit stops at the first block that fits.
//  Free: a search of the header slots, then a walk of the free table to its position.
//  A new request is taken while the previous result waits in the output
//  register; a stalled output holds the sequencer in its last step.
//------------------------------------------------------------------------------
`include "free_list_allocator_macros.svh"

module free_list_allocator import fla_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fla_req_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fla_rsp_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  fla_cmd_t  cmd;
  fla_stat_t st;

  // Registers are always writable
  assign cfg_ready_o = 1'b1;

  fla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  fla_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .st_o        (st)
  );

  // A taken request keeps the input closed until its result is loaded
  `FLA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // Peak never trails the used count it reports with
  `FLA_ASSERT_SAME(a_peak_ge_used, out_valid_o, out_data_o.peak_bytes >= out_data_o.used_bytes)
  // Only a successful allocate carries an address
  `FLA_ASSERT_SAME(a_addr_on_ok, out_valid_o && (out_data_o.status != STAT_OK), out_data_o.data_addr == '0)
  // A new result follows a busy cycle
  `FLA_ASSERT_SAME(a_result_after_busy, $rose(out_valid_o), $past(in_stall_o))

endmodule
